// ===== rtl/core/ufmt_pkg.sv =====
// shared types and constants of the unsigned decimal field formatter
package ufmt_pkg;

	localparam int MAX_FIELD  = 32;
	localparam int VALUE_BITS = 32;

	// decimal digits needed for VALUE_BITS bits: floor(VALUE_BITS * log10(2)) + 1
	localparam int NDIG      = (VALUE_BITS * 30103) / 100000 + 1;
	localparam int DIG_IDX_W = (NDIG > 1) ? $clog2(NDIG) : 1;
	localparam int CNT_W     = $clog2(MAX_FIELD + NDIG + 1);
	localparam int BIT_CNT_W = $clog2(VALUE_BITS);
	localparam int IN_W      = ((VALUE_BITS + 15 + 7) / 8) * 8;
	localparam int OUT_W     = 8;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_SPACE = 8'h20;

	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic [NDIG-1:0][3:0]  bcd_t;

	typedef enum logic [1:0] {
		FS_IDLE,
		FS_CONV,
		FS_PUSH
	} front_state_t;

	// one formatted field waiting for serialization
	typedef struct packed {
		bcd_t digits;
		cnt_t nd;
		cnt_t zeros;
		cnt_t spaces;
		logic left;
	} desc_t;

endpackage

// ===== rtl/core/ufmt_front.sv =====
// front end: accepts a request, converts to decimal and sizes the field
module ufmt_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [ufmt_pkg::IN_W-1:0]     s_tdata,
	output logic                          push,
	output ufmt_pkg::desc_t               push_data,
	input  logic                          full
);
	import ufmt_pkg::*;

	front_state_t state_q, state_d;

	logic [VALUE_BITS-1:0] bin_q;
	bcd_t                  bcd_q;
	bcd_t                  bcd_adj;
	logic [BIT_CNT_W-1:0]  cnt_q;
	cnt_t                  width_q;
	cnt_t                  prec_q;
	logic                  has_prec_q;
	logic                  left_q;
	logic                  zp_q;

	logic [VALUE_BITS-1:0] in_value;
	logic [5:0]            in_width;
	logic [6:0]            in_prec;
	logic                  accept;

	cnt_t nd;
	cnt_t zeros;
	cnt_t used;
	cnt_t fill;
	cnt_t spaces;
	cnt_t total;

	assign in_value = s_tdata[VALUE_BITS-1:0];
	assign in_width = s_tdata[VALUE_BITS+5:VALUE_BITS];
	assign in_prec  = s_tdata[VALUE_BITS+12:VALUE_BITS+6];
	assign accept   = s_tvalid && s_tready;

	// add-3 correction of double dabble
	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			bcd_adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
		end
	end

	// field sizing from the finished digits
	always_comb begin
		nd = cnt_t'(1);
		for (int i = 0; i < NDIG; i++) begin
			if (bcd_q[i] != 4'd0) begin
				nd = cnt_t'(i + 1);
			end
		end
		if (has_prec_q && prec_q == '0 && bcd_q == '0) begin
			nd = '0;
		end
		zeros  = (has_prec_q && prec_q > nd) ? prec_q - nd : '0;
		used   = zeros + nd;
		fill   = (width_q > used) ? width_q - used : '0;
		spaces = fill;
		if (zp_q && !has_prec_q && !left_q) begin
			zeros  = zeros + fill;
			spaces = '0;
		end
		total = spaces + zeros + nd;
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		push     = 1'b0;
		case (state_q)
			FS_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = FS_CONV;
				end
			end
			FS_CONV: begin
				if (cnt_q == '0) begin
					state_d = FS_PUSH;
				end
			end
			FS_PUSH: begin
				if (total == '0) begin
					state_d = FS_IDLE;
				end else if (!full) begin
					push    = 1'b1;
					state_d = FS_IDLE;
				end
			end
			default: begin
				state_d = FS_IDLE;
			end
		endcase
	end

	assign push_data.digits = bcd_q;
	assign push_data.nd     = nd;
	assign push_data.zeros  = zeros;
	assign push_data.spaces = spaces;
	assign push_data.left   = left_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bin_q      <= in_value;
			bcd_q      <= '0;
			cnt_q      <= BIT_CNT_W'(VALUE_BITS - 1);
			width_q    <= (int'(in_width) > MAX_FIELD) ? cnt_t'(MAX_FIELD) : cnt_t'(in_width);
			prec_q     <= (int'(in_prec[5:0]) > MAX_FIELD) ? cnt_t'(MAX_FIELD)
			                                               : cnt_t'(in_prec[5:0]);
			has_prec_q <= !in_prec[6];
			left_q     <= s_tdata[VALUE_BITS+13];
			zp_q       <= s_tdata[VALUE_BITS+14];
		end else if (state_q == FS_CONV) begin
			bcd_q <= {bcd_adj[NDIG-1][2:0], bcd_adj[NDIG-2:0], bin_q[VALUE_BITS-1]};
			bin_q <= {bin_q[VALUE_BITS-2:0], 1'b0};
			cnt_q <= cnt_q - 1'b1;
		end
	end

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("front accepted a request while converting");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("front pushed into a full queue");

	a_push_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> total != '0)
		else $error("front pushed an empty field");

endmodule

// ===== rtl/core/ufmt_fifo.sv =====
// two-entry queue of field descriptors between front and back
module ufmt_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ufmt_pkg::desc_t push_data,
	output logic            full,
	input  logic            pop,
	output ufmt_pkg::desc_t pop_data,
	output logic            not_empty
);
	import ufmt_pkg::*;

	desc_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("queue popped while empty");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("queue count out of range");

endmodule

// ===== rtl/core/ufmt_back.sv =====
// back end: serializes one field into characters
module ufmt_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_valid,
	input  ufmt_pkg::desc_t            q_data,
	output logic                       pop,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [ufmt_pkg::OUT_W-1:0] m_tdata,
	output logic                       m_tlast
);
	import ufmt_pkg::*;

	desc_t      desc_q;
	logic       busy_q;
	cnt_t       k_q;
	logic       m_valid_q;
	logic [7:0] ch_q;
	logic       last_q;

	cnt_t       total;
	cnt_t       di;
	logic [7:0] ch;
	logic       adv;
	logic       is_last;

	assign total   = desc_q.spaces + desc_q.zeros + desc_q.nd;
	assign adv     = busy_q && (!m_valid_q || m_tready);
	assign is_last = (k_q == total - 1'b1);
	assign pop     = !busy_q && q_valid;

	always_comb begin
		di = '0;
		ch = CH_SPACE;
		if (!desc_q.left) begin
			if (k_q < desc_q.spaces) begin
				ch = CH_SPACE;
			end else if (k_q < desc_q.spaces + desc_q.zeros) begin
				ch = CH_ZERO;
			end else begin
				di = desc_q.nd - 1'b1 - (k_q - desc_q.spaces - desc_q.zeros);
				ch = CH_ZERO + {4'b0, desc_q.digits[di[DIG_IDX_W-1:0]]};
			end
		end else begin
			if (k_q < desc_q.zeros) begin
				ch = CH_ZERO;
			end else if (k_q < desc_q.zeros + desc_q.nd) begin
				di = desc_q.nd - 1'b1 - (k_q - desc_q.zeros);
				ch = CH_ZERO + {4'b0, desc_q.digits[di[DIG_IDX_W-1:0]]};
			end else begin
				ch = CH_SPACE;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			desc_q <= q_data;
		end
		if (adv) begin
			ch_q   <= ch;
			last_q <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			k_q       <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				k_q    <= '0;
			end else if (adv) begin
				k_q <= k_q + 1'b1;
				if (is_last) begin
					busy_q <= 1'b0;
				end
			end
			if (adv) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = ch_q;
	assign m_tlast  = last_q;

	a_pos_in_field: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> k_q < total)
		else $error("character position past end of field");

	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && is_last) |=> !busy_q)
		else $error("serializer still busy after last character");

endmodule

// ===== rtl/core/unsigned_decimal_field_formatter_top.sv =====
// top level of the unsigned decimal field formatter
//
//  port group  dir  accept on                 payload
//  s_*         in   s_tvalid && s_tready      value, field_width, precision, left_justify, zero_pad
//  m_*         out  m_tvalid && m_tready      ch, last on m_tlast
//
// the front converts a request with the binary to decimal shift-and-add-3 loop, one bit
// per cycle, then sizes the field and pushes it to the queue
// the back emits one character per cycle while the output is not stalled
// a two-entry queue lets the front convert the next value while the back drains
// output backpressure stalls the back only; the front stalls when the queue is full
// arst_n clears the control state; an empty field yields no item
module unsigned_decimal_field_formatter_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// value, field_width, precision, left_justify, zero_pad
	input  logic [ufmt_pkg::IN_W-1:0]  s_tdata,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// ch
	output logic [ufmt_pkg::OUT_W-1:0] m_tdata,
	output logic                       m_tlast
);
	import ufmt_pkg::*;

	logic  push;
	desc_t push_data;
	logic  full;
	logic  pop;
	desc_t pop_data;
	logic  not_empty;

	ufmt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	ufmt_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.not_empty (not_empty)
	);

	ufmt_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (not_empty),
		.q_data   (pop_data),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

// ===== sim/unsigned_decimal_field_formatter_top_tb.sv =====
// self-checking testbench of the unsigned decimal field formatter with random stream idling
`timescale 1ns / 100ps

module unsigned_decimal_field_formatter_top_tb;

	import ufmt_pkg::*;

	localparam int WID_LSB    = VALUE_BITS;
	localparam int PREC_LSB   = VALUE_BITS + 6;
	localparam int LEFT_BIT   = VALUE_BITS + 13;
	localparam int ZP_BIT     = VALUE_BITS + 14;
	localparam int STALL_LIMIT = 4000;
	localparam int TAIL_CYCLES = 2 * (VALUE_BITS + 2 + MAX_FIELD + 1);
	localparam int RANDOM_REQS = 450;
	localparam logic [6:0] NO_PREC = 7'h7F;

	typedef struct {
		logic [IN_W-1:0] word;
		bit              drain;
	} fmt_req_t;

	typedef struct {
		logic [7:0] ch;
		logic       last;
	} fmt_char_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_W-1:0]  m_tdata;
	logic              m_tlast;

	fmt_req_t  req_q[$];
	fmt_char_t char_q[$];
	int        taken_reqs = 0;
	int        issued_reqs = 0;
	int        burst_left = 0;
	int        gap_left = 0;
	int        ready_mode = 0;
	int        mode_left = 0;
	int        cyc = 0;
	int        stall_cycles = 0;
	int        mismatches = 0;

	unsigned_decimal_field_formatter_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void format_field(logic [IN_W-1:0] word);
		logic [VALUE_BITS-1:0] v;
		logic [5:0]            w_raw;
		logic [6:0]            p_raw;
		logic [7:0]            digs[$];
		logic [7:0]            text[$];
		fmt_char_t             c;
		bit                    has_prec, left, zp;
		int                    width, prec, zeros, spaces, fill;
		v = word[VALUE_BITS-1:0];
		w_raw = word[WID_LSB +: 6];
		p_raw = word[PREC_LSB +: 7];
		left = word[LEFT_BIT];
		zp = word[ZP_BIT];
		has_prec = !p_raw[6];
		width = (w_raw > MAX_FIELD) ? MAX_FIELD : int'(w_raw);
		prec = 0;
		if (has_prec) begin
			prec = (p_raw > MAX_FIELD) ? MAX_FIELD : int'(p_raw);
		end
		if (!(has_prec && prec == 0 && v == 0)) begin
			do begin
				digs.push_front(CH_ZERO + 8'(v % 10));
				v = v / 10;
			end while (v != 0);
		end
		zeros = (has_prec && prec > digs.size()) ? prec - digs.size() : 0;
		fill = width - (zeros + digs.size());
		if (fill < 0) begin
			fill = 0;
		end
		spaces = fill;
		if (zp && !has_prec && !left) begin
			zeros += fill;
			spaces = 0;
		end
		if (!left) begin
			repeat (spaces) text.push_back(CH_SPACE);
		end
		repeat (zeros) text.push_back(CH_ZERO);
		foreach (digs[i]) text.push_back(digs[i]);
		if (left) begin
			repeat (spaces) text.push_back(CH_SPACE);
		end
		foreach (text[i]) begin
			c.ch = text[i];
			c.last = (i == text.size() - 1);
			char_q.push_back(c);
		end
	endfunction

	task automatic add_req(input logic [VALUE_BITS-1:0] v, input logic [5:0] w,
		input logic [6:0] p, input bit left, input bit zp, input bit drain);
		fmt_req_t r;
		r.word = '0;
		r.word[VALUE_BITS-1:0] = v;
		r.word[WID_LSB +: 6] = w;
		r.word[PREC_LSB +: 7] = p;
		r.word[LEFT_BIT] = left;
		r.word[ZP_BIT] = zp;
		r.drain = drain;
		req_q.push_back(r);
	endtask

	// request side: bursts with gaps, holds the head until taken
	always @(negedge clk) begin
		if (arst_n && !(s_tvalid && taken_reqs != issued_reqs)) begin
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (req_q.size() == 0 || (req_q[0].drain && char_q.size() != 0)) begin
				s_tvalid <= 1'b0;
			end else begin
				s_tdata <= req_q[0].word;
				req_q.pop_front();
				s_tvalid <= 1'b1;
				issued_reqs++;
				if (burst_left > 0) begin
					burst_left--;
				end
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 45) : 0;
				end
			end
		end
	end

	// character side stall pattern
	always @(negedge clk) begin
		cyc++;
		if (mode_left == 0) begin
			ready_mode = $urandom_range(0, 3);
			mode_left = $urandom_range(40, 300);
		end else begin
			mode_left--;
		end
		case (ready_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			2: m_tready <= ($urandom_range(0, 3) == 0);
			default: m_tready <= (cyc % 11) < 7;
		endcase
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (char_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("unexpected char %h last %b", m_tdata, m_tlast);
					end
				end else begin
					if (m_tdata !== char_q[0].ch || m_tlast !== char_q[0].last) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("char mismatch: expected %h last %b, got %h last %b",
								char_q[0].ch, char_q[0].last, m_tdata, m_tlast);
						end
					end
					char_q.pop_front();
				end
			end
			if (s_tvalid && s_tready) begin
				format_field(s_tdata);
				taken_reqs++;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && (req_q.size() != 0 || s_tvalid || char_q.size() != 0)) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
			end
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end else begin
			stall_cycles = 0;
		end
	end

	initial begin
		logic [VALUE_BITS-1:0] v;
		logic [5:0]            w;
		logic [6:0]            p;
		logic [VALUE_BITS-1:0] p10;

		add_req(32'd0, 6'd0, NO_PREC, 1'b0, 1'b0, 1'b0);
		add_req(32'd0, 6'd0, 7'd0, 1'b0, 1'b0, 1'b0);
		add_req(32'd0, 6'd5, 7'd0, 1'b0, 1'b0, 1'b0);
		add_req(32'd0, 6'd5, 7'd0, 1'b1, 1'b0, 1'b0);
		add_req(32'd0, 6'd0, 7'd0, 1'b1, 1'b1, 1'b0);
		add_req(32'd0, 6'd3, 7'd0, 1'b0, 1'b1, 1'b0);
		add_req(32'd0, 6'd4, NO_PREC, 1'b0, 1'b1, 1'b0);
		add_req(32'hFFFFFFFF, 6'd0, NO_PREC, 1'b0, 1'b0, 1'b0);
		add_req(32'hFFFFFFFF, 6'd32, NO_PREC, 1'b0, 1'b1, 1'b0);
		add_req(32'hFFFFFFFF, 6'd32, NO_PREC, 1'b1, 1'b1, 1'b0);
		add_req(32'd123, 6'd10, 7'd5, 1'b0, 1'b1, 1'b0);
		add_req(32'd7, 6'd63, NO_PREC, 1'b0, 1'b0, 1'b0);
		add_req(32'd7, 6'd0, 7'd63, 1'b0, 1'b0, 1'b0);
		add_req(32'd9, 6'd33, 7'd33, 1'b1, 1'b0, 1'b0);
		add_req(32'd56, 6'd8, 7'h40, 1'b0, 1'b1, 1'b0);
		add_req(32'd56, 6'd8, 7'h55, 1'b1, 1'b1, 1'b0);
		add_req(32'd1000000000, 6'd5, NO_PREC, 1'b0, 1'b0, 1'b0);
		add_req(32'd42, 6'd6, NO_PREC, 1'b1, 1'b0, 1'b0);
		add_req(32'd42, 6'd20, 7'd10, 1'b1, 1'b0, 1'b0);
		add_req(32'd5, 6'd1, 7'd1, 1'b0, 1'b0, 1'b0);
		add_req(32'd4294967295, 6'd63, 7'd32, 1'b0, 1'b1, 1'b0);
		add_req(32'd31, 6'd2, 7'd0, 1'b0, 1'b1, 1'b1);

		for (int i = 0; i < RANDOM_REQS; i++) begin
			case ($urandom_range(0, 5))
				0: v = 0;
				1: v = $urandom_range(0, 9);
				2: v = $urandom >> $urandom_range(0, 31);
				3: v = $urandom;
				4: begin
					p10 = 1;
					repeat ($urandom_range(0, 9)) p10 = p10 * 10;
					v = p10 - $urandom_range(0, 1);
				end
				default: v = 32'hFFFFFFFF - $urandom_range(0, 3);
			endcase
			case ($urandom_range(0, 7))
				6: w = 6'($urandom_range(0, 32));
				7: w = 6'($urandom_range(33, 63));
				default: w = 6'($urandom_range(0, 12));
			endcase
			case ($urandom_range(0, 9))
				0, 1, 2: p = NO_PREC;
				3: p = 7'($urandom_range(64, 127));
				8: p = 7'($urandom_range(0, 32));
				9: p = 7'($urandom_range(33, 63));
				default: p = 7'($urandom_range(0, 12));
			endcase
			add_req(v, w, p, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				i == 150 || i == 320);
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (req_q.size() != 0 || taken_reqs != issued_reqs) @(posedge clk);
		while (char_q.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0 && char_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
